### rtl/fcd_pkg.sv
// fcd_pkg: types, constants and helpers shared by the fips clause detector
// no dependencies
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned NameLen = 4;
  localparam int unsigned ValLen  = 3;
  localparam int unsigned ProgW   = 3;

  localparam logic [CharW-1:0] ChZero   = 8'h00;
  localparam logic [CharW-1:0] ChComma  = 8'h2c;
  localparam logic [CharW-1:0] ChEq     = 8'h3d;
  localparam logic [CharW-1:0] ChQmark  = 8'h3f;
  localparam logic [CharW-1:0] ChSquote = 8'h27;
  localparam logic [CharW-1:0] ChDquote = 8'h22;

  typedef enum logic [3:0] {
    PH_LEAD         = 4'd0,
    PH_AFTER_Q      = 4'd1,
    PH_NAME         = 4'd2,
    PH_AFTER_NAME   = 4'd3,
    PH_BEFORE_VALUE = 4'd4,
    PH_UNQ_VALUE    = 4'd5,
    PH_QVALUE       = 4'd6,
    PH_TAIL         = 4'd7,
    PH_SPOIL        = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_e;

  // one accepted word handed from the input stage to the scanner
  typedef struct packed {
    logic             step;
    logic [CharW-1:0] char_byte;
  } step_t;

  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_name_char(input logic [CharW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h2e;
  endfunction

  function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  // letters of "fips"
  function automatic logic [CharW-1:0] name_letter(input logic [1:0] idx);
    logic [CharW-1:0] r;
    case (idx)
      2'd0:    r = 8'h66;
      2'd1:    r = 8'h69;
      2'd2:    r = 8'h70;
      2'd3:    r = 8'h73;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // letters of "yes"
  function automatic logic [CharW-1:0] value_letter(input logic [1:0] idx);
    logic [CharW-1:0] r;
    case (idx)
      2'd0:    r = 8'h79;
      2'd1:    r = 8'h65;
      2'd2:    r = 8'h73;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] quote_char(input quote_e k);
    logic [CharW-1:0] r;
    case (k)
      Q_SINGLE: r = ChSquote;
      Q_DOUBLE: r = ChDquote;
      default:  r = ChZero;
    endcase
    return r;
  endfunction

endpackage

### rtl/fcd_if.sv
// fcd_char_if and fcd_result_if: valid/ready channels of the fips clause detector
// depends on fcd_pkg
`timescale 1ns / 1ps

interface fcd_char_if;
  import fcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface fcd_result_if;
  logic valid;
  logic ready;
  logic fips_requested;

  modport source (output valid, output fips_requested, input ready);
  modport sink (input valid, input fips_requested, output ready);
endinterface

### rtl/fips_clause_detector.sv
// fips_clause_detector: top level, input stage, result register and config bit
// depends on fcd_pkg, fcd_if.sv and fcd_scan
`timescale 1ns / 1ps

// Usage
//   char_in carries one query character per word; a zero byte ends the query.
//   res_out carries one word per query, fips_requested, produced only for the
//   zero byte: the default bit OR any clause of the query reading fips=yes.
//   cfg_we_i/cfg_wdata_i write the default-fips bit; write only while idle.
// Path: a character accepted into the input register is scanned from there,
//   and for a terminator the verdict is then loaded into the result register.
// Throughput: one character per cycle while no terminator waits on a full
//   result register; the scan of a character is a single pass through the
//   clause state machine between the input and result registers.
// Stall: the result register holds a finished word; while it waits, plain
//   characters keep flowing, and only a second terminator waits in the input
//   register, which then drops char_in.ready until res_out is taken.
// Reset: rst_ni clears the pipeline, the clause state and the default bit.

module fips_clause_detector
  import fcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fcd_char_if.sink     char_in,
  fcd_result_if.source res_out,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  logic             fips_q, fips_d;
  logic             dflt_q;
  logic             out_free;
  logic             is_term;
  logic             adv;
  logic             scan_result;
  step_t            step;

  assign out_free = !out_vld_q || res_out.ready;
  assign is_term  = (in_byte_q == ChZero);
  assign adv      = in_vld_q && (!is_term || out_free);
  assign char_in.ready = !in_vld_q || adv;

  assign step.step      = adv;
  assign step.char_byte = in_byte_q;

  fcd_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .default_fips_i (dflt_q),
    .result_o       (scan_result)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (char_in.valid && char_in.ready) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;

    out_vld_d = out_vld_q;
    fips_d    = fips_q;
    if (adv && is_term) begin
      out_vld_d = 1'b1;
      fips_d    = scan_result;
    end else if (res_out.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      dflt_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) dflt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_in.valid && char_in.ready) in_byte_q <= char_in.char_byte;
    fips_q <= fips_d;
  end

  assign res_out.valid          = out_vld_q;
  assign res_out.fips_requested = fips_q;

`ifndef SYNTHESIS
  a_result_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv && is_term))
    else $error("result word without a terminator");

  a_ready_only_stage_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !char_in.ready |-> in_vld_q && is_term && !out_free)
    else $error("input stalled without a waiting terminator");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q))
    else $error("input stage lost a character");
`endif

endmodule

### rtl/fcd_scan.sv
// fcd_scan: per-clause state machine and quote tracking of the fips clause detector
// depends on fcd_pkg
`timescale 1ns / 1ps

module fcd_scan
  import fcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t step_i,
  input  logic  default_fips_i,
  output logic  result_o
);

  phase_e           phase_q, phase_d;
  quote_e           quote_q, quote_d;
  logic [ProgW-1:0] name_q, name_d;
  logic [ProgW-1:0] val_q, val_d;
  logic             wsv_q, wsv_d;
  logic             match_q, match_d;

  logic [CharW-1:0] c;
  logic [CharW-1:0] lc;
  logic             ws;
  logic             name_ok;
  logic             val_ok;
  logic             clause_match;

  assign c  = step_i.char_byte;
  assign lc = to_lower(c);
  assign ws = is_ws(c);
  assign name_ok = (name_q < ProgW'(NameLen)) && (lc == name_letter(name_q[1:0]));
  assign val_ok  = (val_q < ProgW'(ValLen)) && (lc == value_letter(val_q[1:0]));

  // outputs
  always_comb begin
    clause_match = (val_q == ProgW'(ValLen)) &&
                   (phase_q == PH_UNQ_VALUE || phase_q == PH_QVALUE ||
                    phase_q == PH_TAIL);
    result_o = default_fips_i | match_q | clause_match;
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    quote_d = quote_q;
    name_d  = name_q;
    val_d   = val_q;
    wsv_d   = wsv_q;
    match_d = match_q;
    if (step_i.step) begin
      if (c == ChZero) begin
        phase_d = PH_LEAD;
        name_d  = '0;
        val_d   = '0;
        wsv_d   = 1'b0;
        quote_d = Q_NONE;
        match_d = 1'b0;
      end else if (c == ChComma && quote_q == Q_NONE) begin
        if (clause_match) match_d = 1'b1;
        phase_d = PH_LEAD;
        name_d  = '0;
        val_d   = '0;
        wsv_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_LEAD, PH_AFTER_Q: begin
            if (!ws) begin
              if (c == ChQmark && phase_q == PH_LEAD) begin
                phase_d = PH_AFTER_Q;
              end else if (is_name_char(c) && name_ok) begin
                name_d  = name_q + 1'b1;
                phase_d = PH_NAME;
              end else begin
                phase_d = PH_SPOIL;
              end
            end
          end
          PH_NAME: begin
            if (ws) begin
              phase_d = PH_AFTER_NAME;
            end else if (c == ChEq) begin
              phase_d = (name_q == ProgW'(NameLen)) ? PH_BEFORE_VALUE : PH_SPOIL;
            end else if (is_name_char(c) && name_ok) begin
              name_d = name_q + 1'b1;
            end else begin
              phase_d = PH_SPOIL;
            end
          end
          PH_AFTER_NAME: begin
            if (!ws) begin
              if (c == ChEq) begin
                phase_d = (name_q == ProgW'(NameLen)) ? PH_BEFORE_VALUE : PH_SPOIL;
              end else begin
                phase_d = PH_SPOIL;
              end
            end
          end
          PH_BEFORE_VALUE: begin
            if (!ws) begin
              if (c == ChSquote || c == ChDquote) begin
                phase_d = PH_QVALUE;
              end else if (val_ok) begin
                val_d   = val_q + 1'b1;
                phase_d = PH_UNQ_VALUE;
              end else begin
                phase_d = PH_SPOIL;
              end
            end
          end
          PH_UNQ_VALUE: begin
            if (ws) begin
              phase_d = PH_TAIL;
            end else if (val_ok) begin
              val_d = val_q + 1'b1;
            end else begin
              phase_d = PH_SPOIL;
            end
          end
          PH_QVALUE: begin
            if (c == quote_char(quote_q)) begin
              phase_d = wsv_q ? PH_SPOIL : PH_TAIL;
            end else if (ws) begin
              // trailing blanks inside quotes only after the full value
              if (val_q == ProgW'(ValLen)) wsv_d = 1'b1;
              else phase_d = PH_SPOIL;
            end else if (wsv_q) begin
              phase_d = PH_SPOIL;
            end else if (val_ok) begin
              val_d = val_q + 1'b1;
            end else begin
              phase_d = PH_SPOIL;
            end
          end
          PH_TAIL: begin
            if (!ws) phase_d = PH_SPOIL;
          end
          default: phase_d = PH_SPOIL;
        endcase
        // quotes open and close even inside a spoiled clause
        if (quote_q == Q_NONE) begin
          if (c == ChSquote) quote_d = Q_SINGLE;
          else if (c == ChDquote) quote_d = Q_DOUBLE;
        end else if (c == quote_char(quote_q)) begin
          quote_d = Q_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      quote_q <= Q_NONE;
      name_q  <= '0;
      val_q   <= '0;
      wsv_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      quote_q <= quote_d;
      name_q  <= name_d;
      val_q   <= val_d;
      wsv_q   <= wsv_d;
      match_q <= match_d;
    end
  end

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.step && step_i.char_byte == ChZero |=>
      phase_q == PH_LEAD && quote_q == Q_NONE && !match_q)
    else $error("query state not cleared after terminator");

  a_match_by_comma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(match_q) |-> $past(step_i.step && step_i.char_byte == ChComma))
    else $error("match flag set without a clause separator");

  a_lead_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEAD || phase_q == PH_AFTER_Q) |-> name_q == '0 && val_q == '0)
    else $error("progress counters dirty at clause start");
`endif

endmodule

### test/fcd_checker.sv
// fcd_checker: watches the character and result channels of fips_clause_detector,
// keeps its own clause scanner and compares every fips_requested word it sees
// depends on fcd_pkg and the channel interfaces in fcd_if.sv
`timescale 1ns / 1ps

module fcd_checker
  import fcd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  fcd_char_if   char_i,
  fcd_result_if res_i,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    checked_o
);

  localparam int MaxReports = 10;
  localparam logic [0:3][7:0] FipsWord = "fips";
  localparam logic [0:2][7:0] YesWord  = "yes";

  phase_e     phase;
  logic [2:0] name_hits;
  logic [2:0] val_len;
  logic       ws_tail;
  quote_e     quote_open;
  logic       any_match;
  logic       default_fips;

  // one entry per terminator still waiting for its verdict word
  logic fips_expect_q [$];
  int   fails = 0;
  int   checked = 0;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_" || c == ".";
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] quote_byte(input quote_e k);
    if (k == Q_SINGLE) return ChSquote;
    if (k == Q_DOUBLE) return ChDquote;
    return ChZero;
  endfunction

  function automatic logic clause_is_fips();
    return val_len == 3 &&
           (phase == PH_UNQ_VALUE || phase == PH_QVALUE || phase == PH_TAIL);
  endfunction

  task automatic clear_clause();
    phase     = PH_LEAD;
    name_hits = '0;
    val_len   = '0;
    ws_tail   = 1'b0;
  endtask

  task automatic take_name(input logic [7:0] c);
    if (name_hits < NameLen && lower_case(c) == FipsWord[name_hits[1:0]]) begin
      name_hits = name_hits + 3'd1;
      phase = PH_NAME;
    end else begin
      phase = PH_SPOIL;
    end
  endtask

  task automatic take_value(input logic [7:0] c, input phase_e next_phase);
    if (val_len < ValLen && lower_case(c) == YesWord[val_len[1:0]]) begin
      val_len = val_len + 3'd1;
      phase = next_phase;
    end else begin
      phase = PH_SPOIL;
    end
  endtask

  task automatic advance_clause(input logic [7:0] c);
    logic ws;
    ws = is_blank(c);
    case (phase)
      PH_LEAD, PH_AFTER_Q: begin
        if (!ws) begin
          if (c == ChQmark && phase == PH_LEAD) phase = PH_AFTER_Q;
          else if (is_word_char(c)) take_name(c);
          else phase = PH_SPOIL;
        end
      end
      PH_NAME: begin
        if (ws) phase = PH_AFTER_NAME;
        else if (c == ChEq) phase = (name_hits == 4) ? PH_BEFORE_VALUE : PH_SPOIL;
        else if (is_word_char(c)) take_name(c);
        else phase = PH_SPOIL;
      end
      PH_AFTER_NAME: begin
        if (!ws) phase = (c == ChEq && name_hits == 4) ? PH_BEFORE_VALUE : PH_SPOIL;
      end
      PH_BEFORE_VALUE: begin
        if (!ws) begin
          if (c == ChSquote || c == ChDquote) phase = PH_QVALUE;
          else take_value(c, PH_UNQ_VALUE);
        end
      end
      PH_UNQ_VALUE: begin
        if (ws) phase = PH_TAIL;
        else take_value(c, PH_UNQ_VALUE);
      end
      PH_QVALUE: begin
        // blanks inside quotes only count after a complete "yes"
        if (c == quote_byte(quote_open)) begin
          phase = ws_tail ? PH_SPOIL : PH_TAIL;
        end else if (ws) begin
          if (val_len == 3) ws_tail = 1'b1;
          else phase = PH_SPOIL;
        end else if (ws_tail) begin
          phase = PH_SPOIL;
        end else begin
          take_value(c, PH_QVALUE);
        end
      end
      PH_TAIL: begin
        if (!ws) phase = PH_SPOIL;
      end
      default: phase = PH_SPOIL;
    endcase
  endtask

  task automatic scan_query_char(input logic [7:0] c);
    if (c == ChZero) begin
      fips_expect_q.push_back(default_fips | any_match | clause_is_fips());
      clear_clause();
      quote_open = Q_NONE;
      any_match  = 1'b0;
    end else if (c == ChComma && quote_open == Q_NONE) begin
      if (clause_is_fips()) any_match = 1'b1;
      clear_clause();
    end else begin
      advance_clause(c);
      // quote tracking runs even in a spoiled clause
      if (quote_open == Q_NONE) begin
        if (c == ChSquote) quote_open = Q_SINGLE;
        else if (c == ChDquote) quote_open = Q_DOUBLE;
      end else if (c == quote_byte(quote_open)) begin
        quote_open = Q_NONE;
      end
    end
  endtask

  task automatic check_result(input logic got);
    logic want;
    if (fips_expect_q.size() == 0) begin
      fails++;
      if (fails <= MaxReports)
        $display("[%0t] result word with no query pending: fips_requested=%b", $time, got);
    end else begin
      want = fips_expect_q.pop_front();
      checked++;
      if (got !== want) begin
        fails++;
        if (fails <= MaxReports)
          $display("[%0t] fips_requested mismatch: expected %b, got %b", $time, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_clause();
      quote_open   = Q_NONE;
      any_match    = 1'b0;
      default_fips = 1'b0;
      fips_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) default_fips = cfg_wdata_i;
      if (res_i.valid && res_i.ready) check_result(res_i.fips_requested);
      if (char_i.valid && char_i.ready) scan_query_char(char_i.char_byte);
      pending_o <= fips_expect_q.size();
    end
  end

endmodule

### test/tb.sv
// tb: drives property queries into fips_clause_detector with bursty input and a
// stalling result side, sets the default-fips bit per phase and reports the verdict
// depends on fcd_pkg, fcd_if.sv, the detector rtl and fcd_checker
`timescale 1ns / 1ps

module tb;
  import fcd_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 4;
  localparam logic [7:0] ChDash = 8'h2d;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_wdata_i;

  fcd_char_if   char_if ();
  fcd_result_if res_if ();

  int fail_count;
  int pending;
  int checked;

  fips_clause_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_in     (char_if),
    .res_out     (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  fcd_checker u_fips_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_if),
    .res_i        (res_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  int cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run stopped after %0d cycles with %0d verdicts outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random hold/stall runs, plus a recurring stretch of steady ready set by the cycle counter
  int   stall_hold = 0;
  logic stall_level = 1'b1;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_hold  = $urandom_range(1, 12);
        stall_level = ($urandom_range(0, 2) != 0);
      end
      stall_hold = stall_hold - 1;
      res_if.ready <= stall_level || (cycles % 1024 < 160);
    end
  end

  int   burst_left = 0;
  int   sent_chars = 0;
  int   sent_queries = 0;
  int   default_queries = 0;
  logic default_now = 1'b0;

  logic [7:0] query_q [$];
  logic [7:0] clause_q [$];

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    char_if.valid     <= 1'b1;
    char_if.char_byte <= c;
    do @(posedge clk_i); while (char_if.ready !== 1'b1);
    burst_left--;
    sent_chars++;
    if (c == ChZero) begin
      sent_queries++;
      if (default_now) default_queries++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // wait until every verdict is back and the pipeline has settled
  task automatic drain();
    char_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_default(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    default_now = v;
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'h09 + k[7:0];
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    return ($urandom_range(0, 1) != 0) ? c - 8'h20 : c;
  endfunction

  // biased toward characters that steer the clause scanner
  function automatic logic [7:0] odd_char();
    string pool;
    pool = "fipsyesFIPSYES?=-,'\" _.\t";
    if ($urandom_range(0, 2) != 0) return pool[$urandom_range(0, pool.len() - 1)];
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) clause_q.push_back(blank_char());
  endtask

  task automatic build_fips_clause();
    string name_s;
    string val_s;
    int    qk;
    name_s = "fips";
    val_s  = "yes";
    clause_q.delete();
    add_blanks(0, 2);
    if ($urandom_range(0, 11) == 0) clause_q.push_back(ChDash);
    if ($urandom_range(0, 3) == 0) clause_q.push_back(ChQmark);
    for (int i = 0; i < 4; i++) clause_q.push_back(mixed_case(name_s[i]));
    add_blanks(0, 2);
    clause_q.push_back(ChEq);
    add_blanks(0, 2);
    qk = $urandom_range(0, 2);
    if (qk != 0) clause_q.push_back((qk == 1) ? ChSquote : ChDquote);
    for (int i = 0; i < 3; i++) clause_q.push_back(mixed_case(val_s[i]));
    if (qk != 0) begin
      if ($urandom_range(0, 3) == 0) add_blanks(1, 2);
      // sometimes leave the quote open to the end of the query
      if ($urandom_range(0, 4) != 0) clause_q.push_back((qk == 1) ? ChSquote : ChDquote);
    end
    add_blanks(0, 2);
  endtask

  task automatic mangle_clause();
    int pos;
    pos = $urandom_range(0, clause_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       clause_q[pos] = odd_char();
      1:       clause_q.insert(pos, odd_char());
      default: clause_q.delete(pos);
    endcase
  endtask

  task automatic random_query();
    int n;
    query_q.delete();
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      if (k > 0) query_q.push_back(ChComma);
      if ($urandom_range(0, 9) < 7) begin
        build_fips_clause();
        if ($urandom_range(0, 2) == 0) mangle_clause();
      end else begin
        clause_q.delete();
        repeat ($urandom_range(0, 8)) clause_q.push_back(odd_char());
      end
      foreach (clause_q[i]) query_q.push_back(clause_q[i]);
    end
    foreach (query_q[i]) send_char(query_q[i]);
    send_char(ChZero);
  endtask

  initial begin
    int phase_end;
    char_if.valid     = 1'b0;
    char_if.char_byte = ChZero;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_default(1'b0);

    // byte extremes in a spoiled clause, then a plain match after the comma
    send_char(8'hff);
    send_char(8'h01);
    send_text(",fips=yes");
    send_char(ChZero);
    // question mark, upper case, quote never closed
    send_text("?FIPS='yes");
    send_char(ChZero);
    drain();
    // default bit forces the verdict on a spoiled clause
    write_default(1'b1);
    send_text("-f");
    send_char(ChZero);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_default(ph % 2 == 1);
      case (ph)
        0:       phase_end = 900;
        1:       phase_end = 1200;
        2:       phase_end = 1800;
        default: phase_end = 1950;
      endcase
      while (sent_chars < phase_end) random_query();
    end
    drain();

    $display("sent %0d characters in %0d queries, %0d of them with the default bit set;",
             sent_chars, sent_queries, default_queries);
    $display("%0d verdict words compared, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/fcd_pkg.sv
rtl/fcd_if.sv
rtl/fcd_scan.sv
rtl/fips_clause_detector.sv
test/fcd_checker.sv
test/tb.sv
